>>> rtl/core/vcsd_pkg.sv
// ----------------------------------------------------------------------------
// vcsd_pkg
// Shared types, command codes and decode helpers of the command stream decoder
// ----------------------------------------------------------------------------
package vcsd_pkg;

    localparam int WAIT_WIDTH_DEF = 32;

    // parser phase
    typedef enum logic [2:0] {
        PH_CMD  = 3'd0,
        PH_OPS  = 3'd1,
        PH_HDR  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    // event codes
    localparam logic [2:0] EV_PSG     = 3'd0;
    localparam logic [2:0] EV_OPLL    = 3'd1;
    localparam logic [2:0] EV_SCC     = 3'd2;
    localparam logic [2:0] EV_WAIT    = 3'd3;
    localparam logic [2:0] EV_END     = 3'd4;
    localparam logic [2:0] EV_UNKNOWN = 3'd5;

    // operand count classes beyond a plain count
    localparam logic [3:0] OPS_SPECIAL = 4'd8;
    localparam logic [3:0] OPS_NONE    = 4'd9;
    localparam logic [3:0] OPS_UNKNOWN = 4'd15;

    // command codes
    localparam logic [7:0] CMD_PSG      = 8'h50;
    localparam logic [7:0] CMD_OPLL     = 8'h51;
    localparam logic [7:0] CMD_WAIT_N   = 8'h61;
    localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
    localparam logic [7:0] CMD_WAIT_PAL = 8'h63;
    localparam logic [7:0] CMD_END      = 8'h66;
    localparam logic [7:0] CMD_DBLOCK   = 8'h67;
    localparam logic [7:0] CMD_PCM      = 8'h68;
    localparam logic [7:0] CMD_WAIT_SHORT = 8'h70;
    localparam logic [7:0] CMD_WAIT_DAC = 8'h80;
    localparam logic [7:0] CMD_PSG_ALT  = 8'hA0;
    localparam logic [7:0] CMD_SCC      = 8'hD2;

    localparam logic [15:0] WAIT_NTSC_SAMPLES = 16'd735;
    localparam logic [15:0] WAIT_PAL_SAMPLES  = 16'd882;

    localparam logic [31:0] DBLOCK_HDR_BYTES = 32'd2;
    localparam logic [31:0] PCM_HDR_BYTES    = 32'd8;
    localparam logic [3:0]  DBLOCK_LEN_BYTES = 4'd4;
    localparam logic [3:0]  PCM_LEN_BYTES    = 4'd3;

    localparam logic [7:0] SCC_BANK_MAX = 8'd5;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [15:0] reg_address;
        logic [7:0]  reg_data;
        logic [31:0] wait_total;
        logic [15:0] loop_count;
    } result_t;

    function automatic logic [3:0] op_count(input logic [7:0] c);
        logic [3:0] n;
        n = OPS_UNKNOWN;
        if (c >= 8'h30 && c <= 8'h3F)
            n = 4'd1;
        else if (c == 8'h40 || c == 8'h4F)
            n = 4'd2;
        else if (c >= 8'h50 && c <= 8'h5F)
            n = 4'd2;
        else if (c == CMD_WAIT_N || c == CMD_PSG_ALT)
            n = 4'd2;
        else if (c == CMD_WAIT_NTSC || c == CMD_WAIT_PAL || c == CMD_END)
            n = OPS_NONE;
        else if (c == CMD_DBLOCK || c == CMD_PCM)
            n = OPS_SPECIAL;
        else if (c >= 8'h70 && c <= 8'h8F)
            n = OPS_NONE;
        else if (c >= 8'h90 && c <= 8'h95)
            n = 4'd4;
        else if (c >= 8'hB0 && c <= 8'hBF)
            n = 4'd2;
        else if (c >= 8'hC0 && c <= 8'hDF)
            n = 4'd3;
        else if (c >= 8'hE0)
            n = 4'd4;
        return n;
    endfunction

    function automatic logic [15:0] scc_bank_base(input logic [2:0] bank);
        logic [15:0] base;
        case (bank)
            3'd0:    base = 16'h9800;
            3'd1:    base = 16'h9880;
            3'd2:    base = 16'h988A;
            3'd3:    base = 16'h988F;
            3'd4:    base = 16'h9800;
            3'd5:    base = 16'h98C0;
            default: base = 16'h9800;
        endcase
        return base;
    endfunction

endpackage

>>> rtl/core/vcsd_parser.sv
// ----------------------------------------------------------------------------
// vcsd_parser
// Byte-wise command parser: phase tracking, operand capture, skip countdown,
// wait accumulator and loop counter
// ----------------------------------------------------------------------------
module vcsd_parser #(
    parameter int WAIT_WIDTH = vcsd_pkg::WAIT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [7:0]        in_byte,
    output logic              res_valid,
    output vcsd_pkg::result_t res
);

    vcsd_pkg::phase_t        phase_reg, phase_next;
    logic [7:0]              cmd_reg, cmd_next;
    logic [7:0]              op_reg [3];
    logic [2:0]              idx_reg, idx_next;
    logic [31:0]             skip_reg, skip_next;
    logic [WAIT_WIDTH-1:0]   wait_reg, wait_next;
    logic [15:0]             loop_reg, loop_next;

    logic [3:0]              n_cmd, n_cur;
    logic [2:0]              idx_inc;
    logic [31:0]             skip_dec;
    logic [7:0]              op0, op1, op2;
    logic                    wait_en;
    logic [15:0]             wait_add;
    logic [63:0]             wait_ext;
    logic                    emit;
    logic [2:0]              kind;
    logic [15:0]             addr;
    logic [7:0]              data;

    assign n_cmd    = vcsd_pkg::op_count(in_byte);
    assign n_cur    = vcsd_pkg::op_count(cmd_reg);
    assign idx_inc  = idx_reg + 3'd1;
    assign skip_dec = (skip_reg != 32'd0) ? skip_reg - 32'd1 : skip_reg;

    // operand view with the byte arriving now in its slot
    assign op0 = (idx_reg == 3'd0) ? in_byte : op_reg[0];
    assign op1 = (idx_reg == 3'd1) ? in_byte : op_reg[1];
    assign op2 = (idx_reg == 3'd2) ? in_byte : op_reg[2];

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        skip_next  = skip_reg;
        loop_next  = loop_reg;
        wait_en    = 1'b0;
        wait_add   = 16'd0;
        emit       = 1'b0;
        kind       = vcsd_pkg::EV_UNKNOWN;
        addr       = 16'd0;
        data       = 8'd0;

        case (phase_reg)
            vcsd_pkg::PH_OPS:
            begin
                idx_next = idx_inc;
                if ({1'b0, idx_inc} >= n_cur)
                begin
                    phase_next = vcsd_pkg::PH_CMD;
                    if (cmd_reg == vcsd_pkg::CMD_PSG || cmd_reg == vcsd_pkg::CMD_PSG_ALT)
                    begin
                        emit = 1'b1;
                        kind = vcsd_pkg::EV_PSG;
                        addr = {8'd0, op0};
                        data = op1;
                    end
                    else if (cmd_reg == vcsd_pkg::CMD_OPLL)
                    begin
                        emit = 1'b1;
                        kind = vcsd_pkg::EV_OPLL;
                        addr = {8'd0, op0};
                        data = op1;
                    end
                    else if (cmd_reg == vcsd_pkg::CMD_SCC)
                    begin
                        emit = 1'b1;
                        if (op0 > vcsd_pkg::SCC_BANK_MAX)
                        begin
                            kind = vcsd_pkg::EV_UNKNOWN;
                        end
                        else
                        begin
                            kind = vcsd_pkg::EV_SCC;
                            addr = vcsd_pkg::scc_bank_base(op0[2:0]) + {8'd0, op1};
                            data = op2;
                        end
                    end
                    else if (cmd_reg == vcsd_pkg::CMD_WAIT_N)
                    begin
                        emit     = 1'b1;
                        kind     = vcsd_pkg::EV_WAIT;
                        wait_en  = 1'b1;
                        wait_add = {op1, op0};
                    end
                end
            end
            vcsd_pkg::PH_HDR:
            begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    phase_next = vcsd_pkg::PH_LEN;
                    idx_next   = 3'd0;
                end
            end
            vcsd_pkg::PH_LEN:
            begin
                // little-endian length, one byte lane per operand index
                skip_next = skip_reg | (32'(in_byte) << {idx_reg[1:0], 3'b000});
                idx_next  = idx_inc;
                if ({1'b0, idx_inc} >= ((cmd_reg == vcsd_pkg::CMD_DBLOCK)
                        ? vcsd_pkg::DBLOCK_LEN_BYTES : vcsd_pkg::PCM_LEN_BYTES))
                begin
                    phase_next = (skip_next == 32'd0) ? vcsd_pkg::PH_CMD
                                                      : vcsd_pkg::PH_DATA;
                end
            end
            vcsd_pkg::PH_DATA:
            begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0)
                    phase_next = vcsd_pkg::PH_CMD;
            end
            default:
            begin
                phase_next = vcsd_pkg::PH_CMD;
                cmd_next   = in_byte;
                idx_next   = 3'd0;
                if (n_cmd == vcsd_pkg::OPS_UNKNOWN)
                begin
                    emit = 1'b1;
                    kind = vcsd_pkg::EV_UNKNOWN;
                end
                else if (n_cmd == vcsd_pkg::OPS_SPECIAL)
                begin
                    skip_next  = (in_byte == vcsd_pkg::CMD_DBLOCK)
                                 ? vcsd_pkg::DBLOCK_HDR_BYTES : vcsd_pkg::PCM_HDR_BYTES;
                    phase_next = vcsd_pkg::PH_HDR;
                end
                else if (n_cmd == vcsd_pkg::OPS_NONE)
                begin
                    emit = 1'b1;
                    if (in_byte == vcsd_pkg::CMD_END)
                    begin
                        kind = vcsd_pkg::EV_END;
                        if (loop_reg != 16'hFFFF)
                            loop_next = loop_reg + 16'd1;
                    end
                    else
                    begin
                        kind    = vcsd_pkg::EV_WAIT;
                        wait_en = 1'b1;
                        if (in_byte == vcsd_pkg::CMD_WAIT_NTSC)
                            wait_add = vcsd_pkg::WAIT_NTSC_SAMPLES;
                        else if (in_byte == vcsd_pkg::CMD_WAIT_PAL)
                            wait_add = vcsd_pkg::WAIT_PAL_SAMPLES;
                        else if (in_byte < vcsd_pkg::CMD_WAIT_DAC)
                            wait_add = {12'd0, in_byte[3:0]} + 16'd1;
                        else
                            wait_add = {12'd0, in_byte[3:0]};
                    end
                end
                else
                begin
                    phase_next = vcsd_pkg::PH_OPS;
                end
            end
        endcase

        if (emit && kind == vcsd_pkg::EV_END)
            wait_next = '0;
        else if (wait_en)
            wait_next = wait_reg + WAIT_WIDTH'(wait_add);
        else
            wait_next = wait_reg;

        wait_ext = 64'(wait_next);

        res.event_kind  = kind;
        res.reg_address = addr;
        res.reg_data    = data;
        res.wait_total  = wait_ext[31:0];
        res.loop_count  = loop_next;
    end

    assign res_valid = in_fire && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= vcsd_pkg::PH_CMD;
            cmd_reg   <= 8'd0;
            idx_reg   <= 3'd0;
            skip_reg  <= 32'd0;
            wait_reg  <= '0;
            loop_reg  <= 16'd0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            idx_reg   <= idx_next;
            skip_reg  <= skip_next;
            wait_reg  <= wait_next;
            loop_reg  <= loop_next;
        end
    end

    // operand capture, payload only
    always_ff @(posedge clk)
    begin
        if (in_fire && phase_reg == vcsd_pkg::PH_OPS && idx_reg < 3'd3)
            op_reg[idx_reg[1:0]] <= in_byte;
    end

endmodule

>>> rtl/core/vcsd_out_skid.sv
// ----------------------------------------------------------------------------
// vcsd_out_skid
// Two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
module vcsd_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vcsd_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output vcsd_pkg::result_t out_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    vcsd_pkg::result_t main_reg, main_next;
    vcsd_pkg::result_t skid_reg, skid_next;
    logic              out_fire;

    assign out_fire  = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (!main_valid_reg || out_fire)
            begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

>>> rtl/core/vgm_command_stream_decoder.sv
// ----------------------------------------------------------------------------
// vgm_command_stream_decoder
// Decodes a VGM command stream byte by byte into chip writes, waits and loops
// ----------------------------------------------------------------------------
//   channel   dir   handshake          payload
//   s_*       in    tvalid / tready    tdata: stream_byte
//   m_*       out   tvalid / tready    tuser: event_kind
//                                      tdata: reg_address, reg_data,
//                                             wait_total, loop_count
//
// one byte per cycle while s_tready is high; each byte is decoded in a
// single pass from the parser state registers into the output register,
// or into the skid register while the output register is held
// s_tready drops only while both output entries hold results
// rst_n clears parser phase, counters and wait total; no clearing pass
// ----------------------------------------------------------------------------
module vgm_command_stream_decoder #(
    parameter int WAIT_WIDTH = vcsd_pkg::WAIT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [15:0] reg_address, [23:16] reg_data,
                                   // [55:24] wait_total, [71:56] loop_count
    output logic [2:0]  m_tuser    // [2:0] event_kind
);

    logic              in_fire;
    logic              res_valid;
    vcsd_pkg::result_t res;
    vcsd_pkg::result_t out_res;

    assign in_fire = s_tvalid && s_tready;

    vcsd_parser #(
        .WAIT_WIDTH (WAIT_WIDTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    vcsd_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tuser = out_res.event_kind;
    assign m_tdata = {out_res.loop_count, out_res.wait_total,
                      out_res.reg_data, out_res.reg_address};

endmodule

>>> tb/vgm_command_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_command_stream_decoder_tb
// Self-checking bench for the command stream decoder
// ----------------------------------------------------------------------------
// Feeds command bytes over the input stream and checks every reported event
// against a cycle-free model of the parser kept in a scoreboard. A directed
// opening covers every command class, the register extremes, bad SCC banks,
// unknown codes and empty blocks. Mostly well-formed random command
// sequences with random operands follow, with pauses until every pending
// event has drained and one burst without idle cycles on either side.
// Otherwise both sides throttle at random.
// ----------------------------------------------------------------------------
module vgm_command_stream_decoder_tb;

    localparam longint CYCLE_LIMIT  = 2_000_000;
    localparam int     RESET_CYCLES = 12;
    localparam int     DRAIN_CYCLES = 32;
    localparam int     MAX_GAP      = 8;

    // commands without a name in the package
    localparam logic [7:0] CMD_SKIP_1OP    = 8'h30;
    localparam logic [7:0] CMD_SKIP_2OP    = 8'h40;
    localparam logic [7:0] CMD_SKIP_2OP_HI = 8'h4F;
    localparam logic [7:0] CMD_SKIP_4OP    = 8'h90;
    localparam logic [7:0] CMD_SKIP_B      = 8'hB0;
    localparam logic [7:0] CMD_SKIP_3OP    = 8'hC0;
    localparam logic [7:0] CMD_SKIP_3OP_HI = 8'hDF;
    localparam logic [7:0] CMD_SKIP_E      = 8'hE0;
    localparam logic [7:0] CMD_SKIP_TOP    = 8'hFF;
    localparam logic [7:0] CMD_BAD_LOW     = 8'h00;
    localparam logic [7:0] CMD_BAD_2F      = 8'h2F;
    localparam logic [7:0] CMD_BAD_41      = 8'h41;
    localparam logic [7:0] CMD_BAD_60      = 8'h60;
    localparam logic [7:0] CMD_BAD_6F      = 8'h6F;
    localparam logic [7:0] CMD_BAD_96      = 8'h96;
    localparam logic [7:0] CMD_BAD_AF      = 8'hAF;

    class command_scoreboard;
        localparam int ARGS_NONE  = 0;
        localparam int ARGS_BLOCK = -1;
        localparam int ARGS_BAD   = -2;
        localparam int REPORT_CAP = 100;

        vcsd_pkg::phase_t  phase;
        logic [7:0]        cmd;
        logic [7:0]        ops [3];
        logic [2:0]        op_idx;
        logic [31:0]       skip_left;
        logic [31:0]       wait_acc;
        logic [15:0]       loops;
        vcsd_pkg::result_t expected [$];
        int                errors;

        function new();
            phase     = vcsd_pkg::PH_CMD;
            cmd       = '0;
            op_idx    = '0;
            skip_left = '0;
            wait_acc  = '0;
            loops     = '0;
            errors    = 0;
            foreach (ops[i]) ops[i] = '0;
        endfunction

        // operand bytes of a command, or one of the ARGS_* classes
        function int arg_class(logic [7:0] c);
            case (c[7:4])
                4'h3:       return 1;
                4'h4:       return (c == CMD_SKIP_2OP || c == CMD_SKIP_2OP_HI) ? 2 : ARGS_BAD;
                4'h5:       return 2;
                4'h6:
                begin
                    if (c == vcsd_pkg::CMD_WAIT_N)
                        return 2;
                    if (c == vcsd_pkg::CMD_WAIT_NTSC || c == vcsd_pkg::CMD_WAIT_PAL
                            || c == vcsd_pkg::CMD_END)
                        return ARGS_NONE;
                    if (c == vcsd_pkg::CMD_DBLOCK || c == vcsd_pkg::CMD_PCM)
                        return ARGS_BLOCK;
                    return ARGS_BAD;
                end
                4'h7, 4'h8: return ARGS_NONE;
                4'h9:       return (c <= 8'h95) ? 4 : ARGS_BAD;
                4'hA:       return (c == vcsd_pkg::CMD_PSG_ALT) ? 2 : ARGS_BAD;
                4'hB:       return 2;
                4'hC, 4'hD: return 3;
                4'hE, 4'hF: return 4;
                default:    return ARGS_BAD;
            endcase
        endfunction

        function logic [15:0] scc_window(logic [2:0] bank);
            case (bank)
                3'd1:    return 16'h9880;
                3'd2:    return 16'h988A;
                3'd3:    return 16'h988F;
                3'd5:    return 16'h98C0;
                default: return 16'h9800;
            endcase
        endfunction

        function void push_event(logic [2:0] kind, logic [15:0] addr, logic [7:0] val);
            vcsd_pkg::result_t r;
            r.event_kind  = kind;
            r.reg_address = addr;
            r.reg_data    = val;
            r.wait_total  = wait_acc;
            r.loop_count  = loops;
            expected.push_back(r);
        endfunction

        function void finish_operands();
            phase = vcsd_pkg::PH_CMD;
            if (cmd == vcsd_pkg::CMD_PSG || cmd == vcsd_pkg::CMD_PSG_ALT)
                push_event(vcsd_pkg::EV_PSG, {8'h00, ops[0]}, ops[1]);
            else if (cmd == vcsd_pkg::CMD_OPLL)
                push_event(vcsd_pkg::EV_OPLL, {8'h00, ops[0]}, ops[1]);
            else if (cmd == vcsd_pkg::CMD_SCC)
            begin
                if (ops[0] > vcsd_pkg::SCC_BANK_MAX)
                    push_event(vcsd_pkg::EV_UNKNOWN, '0, '0);
                else
                    push_event(vcsd_pkg::EV_SCC, scc_window(ops[0][2:0]) + 16'(ops[1]),
                               ops[2]);
            end
            else if (cmd == vcsd_pkg::CMD_WAIT_N)
            begin
                wait_acc = wait_acc + {16'h0000, ops[1], ops[0]};
                push_event(vcsd_pkg::EV_WAIT, '0, '0);
            end
        endfunction

        function void start_command(logic [7:0] c);
            int n;
            n      = arg_class(c);
            cmd    = c;
            op_idx = '0;
            phase  = vcsd_pkg::PH_CMD;
            if (n == ARGS_BAD)
                push_event(vcsd_pkg::EV_UNKNOWN, '0, '0);
            else if (n == ARGS_BLOCK)
            begin
                skip_left = (c == vcsd_pkg::CMD_DBLOCK) ? vcsd_pkg::DBLOCK_HDR_BYTES
                                                        : vcsd_pkg::PCM_HDR_BYTES;
                phase     = vcsd_pkg::PH_HDR;
            end
            else if (n == ARGS_NONE)
            begin
                if (c == vcsd_pkg::CMD_END)
                begin
                    wait_acc = '0;
                    if (loops != 16'hFFFF)
                        loops = loops + 16'd1;
                    push_event(vcsd_pkg::EV_END, '0, '0);
                end
                else
                begin
                    if (c == vcsd_pkg::CMD_WAIT_NTSC)
                        wait_acc = wait_acc + 32'(vcsd_pkg::WAIT_NTSC_SAMPLES);
                    else if (c == vcsd_pkg::CMD_WAIT_PAL)
                        wait_acc = wait_acc + 32'(vcsd_pkg::WAIT_PAL_SAMPLES);
                    else if (c < vcsd_pkg::CMD_WAIT_DAC)
                        wait_acc = wait_acc + 32'(c[3:0]) + 32'd1;
                    else
                        wait_acc = wait_acc + 32'(c[3:0]);
                    push_event(vcsd_pkg::EV_WAIT, '0, '0);
                end
            end
            else
                phase = vcsd_pkg::PH_OPS;
        endfunction

        // advance the parser by one accepted stream byte
        function void note_byte(logic [7:0] b);
            int len_bytes;
            case (phase)
                vcsd_pkg::PH_OPS:
                begin
                    if (op_idx < 3'd3)
                        ops[op_idx] = b;
                    op_idx = op_idx + 3'd1;
                    if (int'(op_idx) >= arg_class(cmd))
                        finish_operands();
                end
                vcsd_pkg::PH_HDR:
                begin
                    if (skip_left != 0)
                        skip_left = skip_left - 32'd1;
                    if (skip_left == 0)
                    begin
                        phase  = vcsd_pkg::PH_LEN;
                        op_idx = '0;
                    end
                end
                vcsd_pkg::PH_LEN:
                begin
                    len_bytes = (cmd == vcsd_pkg::CMD_DBLOCK)
                                ? int'(vcsd_pkg::DBLOCK_LEN_BYTES)
                                : int'(vcsd_pkg::PCM_LEN_BYTES);
                    skip_left = skip_left | (32'(b) << ((8 * int'(op_idx)) & 31));
                    op_idx    = op_idx + 3'd1;
                    if (int'(op_idx) >= len_bytes)
                        phase = (skip_left == 0) ? vcsd_pkg::PH_CMD : vcsd_pkg::PH_DATA;
                end
                vcsd_pkg::PH_DATA:
                begin
                    if (skip_left != 0)
                        skip_left = skip_left - 32'd1;
                    if (skip_left == 0)
                        phase = vcsd_pkg::PH_CMD;
                end
                default:
                    start_command(b);
            endcase
        endfunction

        function void mismatch(string field, longint unsigned want, longint unsigned seen);
            errors++;
            if (errors <= REPORT_CAP)
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, seen);
        endfunction

        function void check_result(logic [2:0] kind, logic [71:0] data);
            vcsd_pkg::result_t e;
            if (expected.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $error("event kind %0d reported with nothing pending", kind);
                return;
            end
            e = expected.pop_front();
            if (kind !== e.event_kind)
                mismatch("event_kind", e.event_kind, kind);
            if (data[15:0] !== e.reg_address)
                mismatch("reg_address", e.reg_address, data[15:0]);
            if (data[23:16] !== e.reg_data)
                mismatch("reg_data", e.reg_data, data[23:16]);
            if (data[55:24] !== e.wait_total)
                mismatch("wait_total", e.wait_total, data[55:24]);
            if (data[71:56] !== e.loop_count)
                mismatch("loop_count", e.loop_count, data[71:56]);
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;

    command_scoreboard sb;
    bit     steady = 1'b0;
    int     fed    = 0;
    longint cycles = 0;

    vgm_command_stream_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // event sink with random back-pressure
    initial
    begin
        int stall;
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tuser, m_tdata);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge clk); while (!s_tready);
        sb.note_byte(b);
        fed++;
    endtask

    // command byte followed by n operand bytes, lowest operand byte first
    task automatic send_cmd(input logic [7:0] c, input logic [31:0] args, input int n);
        send_byte(c);
        for (int i = 0; i < n; i++)
            send_byte(args[8*i +: 8]);
    endtask

    // data block or pcm block; header is 0x66 then random bytes, payload random
    task automatic send_block(input logic [7:0] c, input int len);
        int hdr;
        int len_bytes;
        hdr       = (c == vcsd_pkg::CMD_DBLOCK) ? 1 : 7;
        len_bytes = (c == vcsd_pkg::CMD_DBLOCK) ? int'(vcsd_pkg::DBLOCK_LEN_BYTES)
                                                : int'(vcsd_pkg::PCM_LEN_BYTES);
        send_byte(c);
        send_byte(vcsd_pkg::CMD_END);
        repeat (hdr) send_byte(8'($urandom_range(0, 255)));
        for (int i = 0; i < len_bytes; i++)
            send_byte(8'((len >> (8 * i)) & 255));
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic quiesce();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic random_command();
        int          pick;
        int          len;
        logic [31:0] r;
        logic [7:0]  c;
        pick = $urandom_range(0, 99);
        r    = $urandom;
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 300)
                                             : $urandom_range(0, 6);
        if (pick < 18)
            send_cmd($urandom_range(0, 1) ? vcsd_pkg::CMD_PSG : vcsd_pkg::CMD_PSG_ALT, r, 2);
        else if (pick < 30)
            send_cmd(vcsd_pkg::CMD_OPLL, r, 2);
        else if (pick < 44)
        begin
            // mostly valid banks, now and then a bad one
            c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(6, 255))
                                            : 8'($urandom_range(0, 5));
            send_cmd(vcsd_pkg::CMD_SCC, {r[31:8], c}, 3);
        end
        else if (pick < 56)
            send_cmd(vcsd_pkg::CMD_WAIT_N, r, 2);
        else if (pick < 64)
            send_cmd($urandom_range(0, 1) ? vcsd_pkg::CMD_WAIT_NTSC : vcsd_pkg::CMD_WAIT_PAL,
                     r, 0);
        else if (pick < 74)
            send_cmd(($urandom_range(0, 1) ? vcsd_pkg::CMD_WAIT_SHORT : vcsd_pkg::CMD_WAIT_DAC)
                     | {4'h0, r[3:0]}, r, 0);
        else if (pick < 79)
            send_cmd(vcsd_pkg::CMD_END, r, 0);
        else if (pick < 84)
            send_block(vcsd_pkg::CMD_DBLOCK, len);
        else if (pick < 88)
            send_block(vcsd_pkg::CMD_PCM, len);
        else if (pick < 95)
        begin
            do c = 8'($urandom_range(0, 255)); while (sb.arg_class(c) < 1);
            send_cmd(c, r, sb.arg_class(c));
        end
        else
        begin
            do c = 8'($urandom_range(0, 255));
            while (sb.arg_class(c) != command_scoreboard::ARGS_BAD);
            send_byte(c);
        end
    endtask

    task automatic random_run(input int items);
        int stop;
        stop = fed + items;
        while (fed < stop)
            random_command();
    endtask

    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // register writes at their extremes
        send_cmd(vcsd_pkg::CMD_PSG,     32'h0000_0000, 2);
        send_cmd(vcsd_pkg::CMD_PSG_ALT, 32'h0000_FFFF, 2);
        send_cmd(vcsd_pkg::CMD_OPLL,    32'h0000_A53F, 2);
        send_cmd(vcsd_pkg::CMD_SCC,     32'h0000_0000, 3);
        send_cmd(vcsd_pkg::CMD_SCC,     32'h00FF_FF05, 3);
        send_cmd(vcsd_pkg::CMD_SCC,     32'h005A_7F03, 3);
        // banks above five are reported as unknown
        send_cmd(vcsd_pkg::CMD_SCC,     32'h0022_1106, 3);
        send_cmd(vcsd_pkg::CMD_SCC,     32'h0033_44FF, 3);
        // every wait form, including the zero-sample one
        send_cmd(vcsd_pkg::CMD_WAIT_N,    32'h0000_0000, 2);
        send_cmd(vcsd_pkg::CMD_WAIT_N,    32'h0000_FFFF, 2);
        send_cmd(vcsd_pkg::CMD_WAIT_NTSC, 32'h0, 0);
        send_cmd(vcsd_pkg::CMD_WAIT_PAL,  32'h0, 0);
        send_cmd(vcsd_pkg::CMD_WAIT_SHORT,         32'h0, 0);
        send_cmd(vcsd_pkg::CMD_WAIT_SHORT | 8'h0F, 32'h0, 0);
        send_cmd(vcsd_pkg::CMD_WAIT_DAC,           32'h0, 0);
        send_cmd(vcsd_pkg::CMD_WAIT_DAC | 8'h0F,   32'h0, 0);
        send_cmd(vcsd_pkg::CMD_END, 32'h0, 0);
        send_byte(CMD_BAD_LOW);
        send_byte(CMD_BAD_2F);
        send_byte(CMD_BAD_41);
        send_byte(CMD_BAD_60);
        send_byte(CMD_BAD_6F);
        send_byte(CMD_BAD_96);
        send_byte(CMD_BAD_AF);
        send_cmd(CMD_SKIP_1OP,    32'h0000_00FF, 1);
        send_cmd(CMD_SKIP_2OP,    32'h0000_1234, 2);
        send_cmd(CMD_SKIP_2OP_HI, 32'h0000_5678, 2);
        send_cmd(CMD_SKIP_4OP,    32'hFFFF_FFFF, 4);
        send_cmd(CMD_SKIP_B,      32'h0000_0000, 2);
        send_cmd(CMD_SKIP_3OP,    32'h00AB_CDEF, 3);
        send_cmd(CMD_SKIP_3OP_HI, 32'h0066_6766, 3);
        send_cmd(CMD_SKIP_E,      32'h6667_6866, 4);
        send_cmd(CMD_SKIP_TOP,    32'h8000_0001, 4);
        // empty and short blocks
        send_block(vcsd_pkg::CMD_DBLOCK, 0);
        send_block(vcsd_pkg::CMD_DBLOCK, 3);
        send_block(vcsd_pkg::CMD_PCM, 0);
        send_block(vcsd_pkg::CMD_PCM, 2);
        send_cmd(vcsd_pkg::CMD_PSG, 32'h0000_0102, 2);

        random_run(1200);
        quiesce();

        // back to back on both sides
        steady = 1'b1;
        random_run(300);
        steady = 1'b0;
        quiesce();

        random_run(300);

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
